/* src/cfb_pkg.sv */
// shared types, constants and crc function for the command frame builder
`default_nettype none

package cfb_pkg;

    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [15:0] SIGN_RESET = 16'h484C;
    localparam logic [15:0] CMD_RESET  = 16'h0043;

    // register indexes on the config port (byte address bit 2)
    localparam logic REG_SIGN = 1'b0;
    localparam logic REG_CMD  = 1'b1;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic        hdr;       // emit the two header words first
        logic        has_data;  // emit a payload word
        logic        fin;       // close the frame with the crc word
        logic [31:0] word;      // packed payload word
        logic [15:0] seq;       // sequence number for header word 1
        logic [15:0] plen;      // padded length for header word 1
    } cmd_t;

    typedef enum logic [1:0] {
        STEP_HDR0,
        STEP_HDR1,
        STEP_DATA,
        STEP_CRC
    } step_t;

    // crc-32/mpeg-2 over one word, msb first; flattens to an xor network
    function automatic logic [31:0] crc32_word(input logic [31:0] crc,
                                               input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int k = 0; k < 32; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/cfb_front.sv */
// front end: accepts bytes, packs payload words and queues frame commands
`default_nettype none

module cfb_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,   // data_byte, msg_len, seq_number
    input  wire logic          s_tuser,   // first_byte
    input  wire logic          s_tlast,   // last_byte
    input  wire logic          q_full,
    output logic               push,
    output cfb_pkg::cmd_t      push_cmd
);

    logic [23:0] partial_reg, partial_next;
    logic [1:0]  lane_reg, lane_next;

    logic        accept;
    logic [7:0]  data_byte;
    logic [15:0] msg_len;
    logic [15:0] seq_number;
    logic [16:0] len_sum;
    logic [1:0]  lane_eff;
    logic [23:0] part_eff;
    logic [31:0] word;
    logic        zero_start;
    logic        emit_data;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign data_byte  = s_tdata[7:0];
    assign msg_len    = s_tdata[23:8];
    assign seq_number = s_tdata[39:24];
    assign len_sum    = {1'b0, msg_len} + 17'd3;

    // a start drops any open partial word
    assign lane_eff   = s_tuser ? 2'd0 : lane_reg;
    assign part_eff   = s_tuser ? 24'd0 : partial_reg;
    assign zero_start = s_tuser && (msg_len == 16'd0);
    assign emit_data  = !zero_start && ((lane_eff == 2'd3) || s_tlast);

    always_comb begin
        case (lane_eff)
            2'd0:    word = {24'd0, data_byte};
            2'd1:    word = {16'd0, data_byte, part_eff[7:0]};
            2'd2:    word = {8'd0, data_byte, part_eff[15:0]};
            2'd3:    word = {data_byte, part_eff};
            default: word = 32'd0;
        endcase
    end

    always_comb begin
        push_cmd.hdr      = s_tuser;
        push_cmd.has_data = emit_data;
        push_cmd.fin      = zero_start || s_tlast;
        push_cmd.word     = word;
        push_cmd.seq      = seq_number;
        push_cmd.plen     = {len_sum[15:2], 2'b00};
        push              = accept && (s_tuser || emit_data);

        partial_next = partial_reg;
        lane_next    = lane_reg;
        if (accept) begin
            if (zero_start || emit_data) begin
                partial_next = 24'd0;
                lane_next    = 2'd0;
            end else begin
                partial_next = word[23:0];
                lane_next    = lane_eff + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= 24'd0;
            lane_reg    <= 2'd0;
        end else begin
            partial_reg <= partial_next;
            lane_reg    <= lane_next;
        end
    end

endmodule

`default_nettype wire

/* src/cfb_queue.sv */
// small register queue between the front and back ends
`default_nettype none

module cfb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire cfb_pkg::cmd_t  push_cmd,
    input  wire logic           pop,
    output cfb_pkg::cmd_t       head,
    output logic                empty,
    output logic                full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfb_pkg::cmd_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* src/cfb_back.sv */
// back end: steps through header, payload and crc words into the output register
`default_nettype none

module cfb_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [15:0]    header_sign,
    input  wire logic [15:0]    command_code,
    input  wire cfb_pkg::cmd_t  head,
    input  wire logic           q_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [31:0]         m_tdata,
    output logic                m_tlast
);

    cfb_pkg::step_t step_reg, step_next, start_step, cur_step;
    logic           begun_reg, begun_next;
    logic [31:0]    crc_reg, crc_next;
    logic           valid_reg, valid_next;
    logic [31:0]    data_reg, data_next;
    logic           last_reg, last_next;

    logic           out_ok;
    logic           emit;
    logic           more;
    logic           is_last;
    logic [31:0]    word;
    logic [31:0]    crc_base;
    logic [31:0]    crc_calc;

    assign out_ok = !valid_reg || m_tready;
    assign emit   = !q_empty && out_ok;

    assign start_step = head.hdr      ? cfb_pkg::STEP_HDR0 :
                        head.has_data ? cfb_pkg::STEP_DATA : cfb_pkg::STEP_CRC;
    assign cur_step   = begun_reg ? step_reg : start_step;

    always_comb begin
        word      = head.word;
        more      = 1'b0;
        is_last   = 1'b0;
        step_next = step_reg;
        case (cur_step)
            cfb_pkg::STEP_HDR0: begin
                word      = {command_code, header_sign};
                more      = 1'b1;
                step_next = cfb_pkg::STEP_HDR1;
            end
            cfb_pkg::STEP_HDR1: begin
                word      = {head.plen, head.seq};
                more      = head.has_data || head.fin;
                step_next = head.has_data ? cfb_pkg::STEP_DATA : cfb_pkg::STEP_CRC;
            end
            cfb_pkg::STEP_DATA: begin
                word      = head.word;
                more      = head.fin;
                step_next = cfb_pkg::STEP_CRC;
            end
            cfb_pkg::STEP_CRC: begin
                word      = crc_reg;
                is_last   = 1'b1;
                step_next = cfb_pkg::STEP_HDR0;
            end
            default: begin
                word      = head.word;
                step_next = cfb_pkg::STEP_HDR0;
            end
        endcase
    end

    // header word 0 restarts the crc
    assign crc_base = (cur_step == cfb_pkg::STEP_HDR0) ? cfb_pkg::CRC_INIT : crc_reg;
    assign crc_calc = cfb_pkg::crc32_word(crc_base, word);

    always_comb begin
        crc_next   = crc_reg;
        begun_next = begun_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        if (emit) begin
            crc_next   = is_last ? cfb_pkg::CRC_INIT : crc_calc;
            begun_next = more;
            data_next  = word;
            last_next  = is_last;
            valid_next = 1'b1;
        end
    end

    assign pop      = emit && !more;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= cfb_pkg::STEP_HDR0;
            begun_reg <= 1'b0;
            crc_reg   <= cfb_pkg::CRC_INIT;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= emit ? step_next : step_reg;
            begun_reg <= begun_next;
            crc_reg   <= crc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    a_crc_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && cur_step == cfb_pkg::STEP_CRC) |=> (crc_reg == cfb_pkg::CRC_INIT))
        else $error("crc not restored after frame end");

    a_begun_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        begun_reg |-> !q_empty)
        else $error("entry in progress but queue empty");

    a_crc_word_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && cur_step == cfb_pkg::STEP_CRC) |=> (m_tvalid && m_tlast))
        else $error("crc word not marked last");

    a_pop_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cur_step == cfb_pkg::STEP_CRC || !head.fin))
        else $error("entry dropped before its crc word");

endmodule

`default_nettype wire

/* src/command_frame_builder_crc32.sv */
// top level of the command frame builder: config registers, front, queue and back end
// a completed payload word passes through the command queue, then the output register on m_tdata
// throughput: one byte per cycle; the back end issues one frame word per cycle while the output
//   register can take it; a start item causes up to four words, which the command queue absorbs;
//   s_tready falls only while the queue is full, i.e. while the output side is the bottleneck
// reset: synchronous active-low aresetn clears queue, packer, crc and output valid;
//   header_sign and command_code return to 0x484C and 0x0043
`default_nettype none

module command_frame_builder_crc32 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    // byte input, one message byte per word
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,   // [7:0] data_byte, [23:8] msg_len, [39:24] seq_number
    input  wire logic          s_tuser,   // [0] first_byte
    input  wire logic          s_tlast,   // last_byte

    // frame word output
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,   // [31:0] frame_word
    output logic               m_tlast,   // word_last, set on the crc word

    // config port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0]   sign_reg, sign_next;
    logic [15:0]   cmd_reg, cmd_next;
    logic          cfg_wr;

    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    cfb_pkg::cmd_t q_in;
    cfb_pkg::cmd_t q_head;

    // config registers, word-aligned; only address bit 2 selects
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        sign_next = sign_reg;
        cmd_next  = cmd_reg;
        if (cfg_wr) begin
            case (paddr[2])
                cfb_pkg::REG_SIGN: sign_next = pwdata[15:0];
                cfb_pkg::REG_CMD:  cmd_next  = pwdata[15:0];
                default:           sign_next = sign_reg;
            endcase
        end
        case (paddr[2])
            cfb_pkg::REG_SIGN: prdata = {16'd0, sign_reg};
            cfb_pkg::REG_CMD:  prdata = {16'd0, cmd_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_reg <= cfb_pkg::SIGN_RESET;
            cmd_reg  <= cfb_pkg::CMD_RESET;
        end else begin
            sign_reg <= sign_next;
            cmd_reg  <= cmd_next;
        end
    end

    // front: byte packing and command classification
    cfb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_in)
    );

    // decoupling queue
    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back: header, payload and crc word sequencing
    cfb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .header_sign  (sign_reg),
        .command_code (cmd_reg),
        .head         (q_head),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    // the front only pushes when the queue has room
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("push into full queue");

    // an item that starts a frame always leaves a command behind
    a_start_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !q_empty)
        else $error("frame start lost");

    // nothing leaves the queue while empty
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* dv/command_frame_builder_crc32_tb.sv */
// self-checking testbench for the command frame builder with crc-32/mpeg-2 trailer
`timescale 1ns / 100ps

module command_frame_builder_crc32_tb;

    // no word moved on either side for the whole of this limit ends the run
    localparam int STALL_LIMIT = 1000;
    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 355;
    // covers the output register plus the command queue draining
    localparam int DRAIN_CYCLES = 16;

    // one byte word as the sender sees it
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] len;
        logic [15:0] seq;
    } msg_byte_t;

    // one frame word as the receiver sees it
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } frame_word_t;

    // directed row: byte fields, then the header words where they are known by hand
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] len;
        logic [15:0] seq;
        logic        typed;
        logic [31:0] hdr0;
        logic [31:0] hdr1;
    } directed_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [7:0] data_byte, [23:8] msg_len, [39:24] seq_number
    logic        s_tuser;   // [0] first_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [31:0] frame_word
    logic        m_tlast;   // word_last
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    command_frame_builder_crc32 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state: config copy plus the running frame
    logic [15:0] hdr_sign;
    logic [15:0] cmd_code;
    logic [31:0] run_crc;
    logic [23:0] open_word;
    logic [1:0]  open_lane;

    frame_word_t pending_words[$];   // frame words still owed by the block
    int          errors;
    int          idle_cycles = 0;
    bit          steady;             // no idling on either side while set

    // directed stimulus, header words typed in where they follow from the fields
    directed_row_t directed_rows [N_DIRECTED] = '{
        // byte with no start right after reset, left open
        '{8'hA5, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        // zero-length start drops the open byte; data and last are ignored
        '{8'hFF, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1, 32'h0043_484C, 32'h0000_0000},
        '{8'h00, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 32'h0043_484C, 32'h0000_FFFF},
        // top length wraps the padded length to zero, single byte frame
        '{8'h12, 1'b1, 1'b1, 16'hFFFF, 16'h1234, 1'b1, 32'h0043_484C, 32'h0000_1234},
        // largest length that does not wrap
        '{8'h00, 1'b1, 1'b0, 16'hFFFC, 16'hAAAA, 1'b1, 32'h0043_484C, 32'hFFFC_AAAA},
        '{8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'hAA, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h01, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h80, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        // length mismatch: frame ends on last, two-byte padded word
        '{8'hFE, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        // bytes with no start after a closed frame
        '{8'h12, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h34, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h11, 1'b1, 1'b0, 16'h0008, 16'h0001, 1'b1, 32'h0043_484C, 32'h0008_0001},
        '{8'h22, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h33, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        // start within a frame restarts packing and crc
        '{8'h44, 1'b1, 1'b0, 16'h0005, 16'h0002, 1'b1, 32'h0043_484C, 32'h0008_0002},
        '{8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h66, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h77, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'h88, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        // first and last on one word
        '{8'hC3, 1'b1, 1'b1, 16'h0003, 16'h5555, 1'b1, 32'h0043_484C, 32'h0004_5555},
        // padded length wraps again
        '{8'h7F, 1'b1, 1'b0, 16'hFFFD, 16'h8000, 1'b1, 32'h0043_484C, 32'h0000_8000},
        '{8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0},
        // last on the fourth lane: full word then crc
        '{8'h5A, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0}
    };

    // crc-32/mpeg-2 over one word, msb first
    function automatic logic [31:0] crc_mpeg2_word(input logic [31:0] crc,
                                                   input logic [31:0] word);
        logic [31:0] acc;
        acc = crc ^ word;
        for (int b = 0; b < 32; b++) begin
            if (acc[31]) begin
                acc = {acc[30:0], 1'b0} ^ cfb_pkg::CRC_POLY;
            end else begin
                acc = {acc[30:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // header and payload words go through the crc
    task automatic owe_data_word(input logic [31:0] word);
        run_crc = crc_mpeg2_word(run_crc, word);
        pending_words.push_back('{word, 1'b0});
    endtask

    // crc word ends the frame and rewinds the packer
    task automatic owe_crc_word();
        pending_words.push_back('{run_crc, 1'b1});
        run_crc   = cfb_pkg::CRC_INIT;
        open_word = '0;
        open_lane = '0;
    endtask

    // frame words caused by one accepted byte word
    task automatic build_expected_words(input msg_byte_t b);
        logic [16:0] rounded;
        logic [31:0] word;
        if (b.first) begin
            rounded   = {1'b0, b.len} + 17'd3;
            run_crc   = cfb_pkg::CRC_INIT;
            open_word = '0;
            open_lane = '0;
            owe_data_word({cmd_code, hdr_sign});
            // padded length modulo 2^16
            owe_data_word({rounded[15:2], 2'b00, b.seq});
            if (b.len == 16'd0) begin
                owe_crc_word();
                return;
            end
        end
        word = {8'h00, open_word} | ({24'h0, b.data} << (8 * open_lane));
        if (open_lane == 2'd3 || b.last) begin
            owe_data_word(word);
            open_word = '0;
            open_lane = '0;
        end else begin
            open_word = word[23:0];
            open_lane = open_lane + 2'd1;
        end
        if (b.last) begin
            owe_crc_word();
        end
    endtask

    // offer one byte word, with an occasional gap before it; mark is where its
    // frame words start in the expectation queue
    task automatic send_byte(input msg_byte_t b, output int mark);
        if (!steady && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.seq, b.len, b.data};
        s_tuser  <= b.first;
        s_tlast  <= b.last;
        do @(posedge aclk); while (!s_tready);
        mark = pending_words.size();
        build_expected_words(b);
    endtask

    // write a register, read it back
    task automatic program_register(input logic idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == cfb_pkg::REG_SIGN) begin
            hdr_sign = value;
        end else begin
            cmd_code = value;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {16'h0000, value}) begin
            errors++;
            $display("%0t: register %0d readback mismatch: expected %h, got %h",
                     $time, idx, {16'h0000, value}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stop the sender, let every owed word come out, then program both registers
    task automatic settle_then_program(input logic [15:0] sign, input logic [15:0] cmd);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        // a byte with no result may still sit in the packer
        repeat (DRAIN_CYCLES) @(posedge aclk);
        program_register(cfb_pkg::REG_SIGN, sign);
        program_register(cfb_pkg::REG_CMD, cmd);
        @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: random backpressure, every accepted word checked against the oldest owed
    always @(posedge aclk) begin : drain
        frame_word_t oldest;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame word: expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                oldest = pending_words.pop_front();
                if (m_tdata !== oldest.word) begin
                    errors++;
                    $display("%0t: frame_word mismatch: expected %h, got %h",
                             $time, oldest.word, m_tdata);
                end
                if (m_tlast !== oldest.last) begin
                    errors++;
                    $display("%0t: word_last mismatch: expected %b, got %b",
                             $time, oldest.last, m_tlast);
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 14);
        end
    end

    // watchdog: any word moving on either side resets the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        directed_row_t row;
        msg_byte_t     b;
        int            mark;
        int            sent;
        int            phase;
        int            kind;
        int            pick;
        int            nbytes;
        int            count;

        // every input known from time zero
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        errors      = 0;
        steady      = 1'b0;
        hdr_sign    = cfb_pkg::SIGN_RESET;
        cmd_code    = cfb_pkg::CMD_RESET;
        run_crc     = cfb_pkg::CRC_INIT;
        open_word   = '0;
        open_lane   = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset config; typed header words replace the predicted ones
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            b   = '{row.data, row.first, row.last, row.len, row.seq};
            send_byte(b, mark);
            if (row.typed) begin
                pending_words[mark].word     = row.hdr0;
                pending_words[mark + 1].word = row.hdr1;
            end
        end

        // low extremes for both registers
        settle_then_program(16'h0000, 16'h0000);

        // random part: mostly well-formed frames, some stray bytes and cut-off frames
        sent  = 0;
        phase = 0;
        while (sent < N_RANDOM) begin
            if (phase == 0 && sent >= 130) begin
                settle_then_program(16'hFFFF, 16'hFFFF);
                phase = 1;
            end else if (phase == 1 && sent >= 260) begin
                settle_then_program(16'($urandom), 16'($urandom));
                phase = 2;
            end
            steady = (sent >= 150 && sent < 230);
            kind   = $urandom_range(0, 99);
            pick   = $urandom_range(0, 99);
            nbytes = (pick < 10) ? 0 :
                     (pick < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            if (kind < 75) begin
                // whole frame; the length field sometimes lies
                count = (nbytes == 0) ? 1 : nbytes;
                for (int k = 0; k < count; k++) begin
                    b.data  = 8'($urandom);
                    b.first = (k == 0);
                    b.last  = (nbytes == 0) ? 1'($urandom_range(0, 1)) : (k == nbytes - 1);
                    if (k == 0) begin
                        b.len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(nbytes);
                    end else begin
                        b.len = 16'($urandom);
                    end
                    b.seq = 16'($urandom);
                    send_byte(b, mark);
                    sent++;
                end
            end else if (kind < 85) begin
                // bytes with no start
                count = $urandom_range(1, 6);
                for (int k = 0; k < count; k++) begin
                    b.data  = 8'($urandom);
                    b.first = 1'b0;
                    b.last  = ($urandom_range(0, 3) == 0);
                    b.len   = 16'($urandom);
                    b.seq   = 16'($urandom);
                    send_byte(b, mark);
                    sent++;
                end
            end else begin
                // frame cut short, the next start discards it
                count = $urandom_range(1, 6);
                for (int k = 0; k < count; k++) begin
                    b.data  = 8'($urandom);
                    b.first = (k == 0);
                    b.last  = 1'b0;
                    b.len   = (k == 0) ? 16'(nbytes + $urandom_range(1, 8)) : 16'($urandom);
                    b.seq   = 16'($urandom);
                    send_byte(b, mark);
                    sent++;
                end
            end
        end
        steady = 1'b0;

        // drain, then wait DRAIN_CYCLES so the pipe can show any stray word
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
